@@ design/wrtd_pkg.sv @@
`default_nettype none

package wrtd_pkg;

  // field widths
  localparam int COORD_W = 16;
  localparam int DELTA_W = 17;
  localparam int ANGLE_W = 17;
  localparam int ERR_W   = 18;
  localparam int GAIN_W  = 16;
  localparam int HDZ_W   = 15;
  localparam int OUT_W   = 24;
  localparam int REQ_W   = 16;
  localparam int CMD_W   = 26;

  // cordic datapath: offsets scaled by 2^16, angle in Q28
  localparam int CV_W = 36;
  localparam int Z_W  = 32;
  localparam int ATAN_IDX_W = 5;
  localparam logic signed [Z_W-1:0] PI_Q28 = 32'sd843314857;

  // square root datapath
  localparam int SQ_W   = 34;
  localparam int ROOT_W = 17;

  // shared multiplier
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_GAIN     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_GAIN     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_DEADZONE = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADING_DEADZONE  = 8'd3;

  localparam logic [GAIN_W-1:0]  POSITION_GAIN_RST     = 16'd8192;
  localparam logic [GAIN_W-1:0]  ROTATION_GAIN_RST     = 16'd2458;
  localparam logic [GAIN_W-1:0]  DISTANCE_DEADZONE_RST = 16'd256;
  localparam logic [HDZ_W-1:0]   HEADING_DEADZONE_RST  = 15'd2048;

  // default parameter values
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int INDEX_WIDTH_DEF  = 16;

  // atan(2^-i) in Q28
  function automatic logic signed [Z_W-1:0] atan_q28(input logic [ATAN_IDX_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 32'sd210828714;
      5'd1:  v = 32'sd124459457;
      5'd2:  v = 32'sd65760959;
      5'd3:  v = 32'sd33381290;
      5'd4:  v = 32'sd16755422;
      5'd5:  v = 32'sd8385879;
      5'd6:  v = 32'sd4193963;
      5'd7:  v = 32'sd2097109;
      5'd8:  v = 32'sd1048571;
      5'd9:  v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      5'd24: v = 32'sd16;
      5'd25: v = 32'sd8;
      5'd26: v = 32'sd4;
      5'd27: v = 32'sd2;
      5'd28: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp a wheel command sum to the output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [CMD_W:0] v);
    logic signed [CMD_W:0] hi;
    logic signed [CMD_W:0] lo;
    logic signed [OUT_W-1:0] r;
    hi = (CMD_W+1)'(2**(OUT_W-1) - 1);
    lo = -(CMD_W+1)'(2**(OUT_W-1));
    if (v > hi) begin
      r = hi[OUT_W-1:0];
    end else if (v < lo) begin
      r = lo[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/wrtd_if.sv @@
`default_nettype none

// pose sample channel
interface wrtd_pose_if;
  import wrtd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] robot_x;
  logic signed [COORD_W-1:0] robot_y;
  logic signed [COORD_W-1:0] robot_heading;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  modport source (output valid, robot_x, robot_y, robot_heading, target_x, target_y,
                  input ready);
  modport sink (input valid, robot_x, robot_y, robot_heading, target_x, target_y,
                output ready);
endinterface

// wheel command channel
interface wrtd_cmd_if;
  import wrtd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] right_speed;
  logic signed [OUT_W-1:0] left_speed;
  logic                    point_reached;
  logic [REQ_W-1:0]        requested_index;
  modport source (output valid, right_speed, left_speed, point_reached, requested_index,
                  input ready);
  modport sink (input valid, right_speed, left_speed, point_reached, requested_index,
                output ready);
endinterface

// register write channel
interface wrtd_cfg_if;
  import wrtd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/wrtd_cordic.sv @@
`default_nettype none

module wrtd_cordic #(
  parameter int STEPS = wrtd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic signed [wrtd_pkg::DELTA_W-1:0]  dx,
  input  wire logic signed [wrtd_pkg::DELTA_W-1:0]  dy,
  output logic                                      done,
  output logic signed [wrtd_pkg::ANGLE_W-1:0]       angle
);
  import wrtd_pkg::*;

  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  logic                     busy;
  logic [STEP_W-1:0]        step;
  logic signed [CV_W-1:0]   x;
  logic signed [CV_W-1:0]   y;
  logic signed [Z_W-1:0]    z;
  logic signed [CV_W-1:0]   x0;
  logic signed [CV_W-1:0]   y0;
  logic signed [CV_W-1:0]   xs;
  logic signed [CV_W-1:0]   ys;
  logic signed [Z_W-1:0]    step_angle;
  logic signed [Z_W:0]      z_rnd;
  logic                     y_pos;
  logic                     y_neg;

  // scaled offsets
  assign x0 = {{(CV_W-DELTA_W-16){dx[DELTA_W-1]}}, dx, 16'b0};
  assign y0 = {{(CV_W-DELTA_W-16){dy[DELTA_W-1]}}, dy, 16'b0};

  // floor shifts and table lookup for the current step
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign step_angle = atan_q28(ATAN_IDX_W'(step));
  assign y_neg = y[CV_W-1];
  assign y_pos = !y[CV_W-1] && (y != '0);

  // angle rounded half up from Q28 to Q12
  assign z_rnd = {z[Z_W-1], z} + (Z_W+1)'(32768);
  assign angle = ANGLE_W'(z_rnd >>> 16);

  // vectoring iterations, one per cycle
  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (step == LAST_STEP);
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      z    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      if (dx[DELTA_W-1]) begin
        x <= -x0;
        y <= -y0;
        z <= dy[DELTA_W-1] ? -PI_Q28 : PI_Q28;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (busy) begin
      if (y_pos) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step_angle;
      end else if (y_neg) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step_angle;
      end
      if (step == LAST_STEP) begin
        busy <= 1'b0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/wrtd_isqrt.sv @@
`default_nettype none

module wrtd_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [wrtd_pkg::SQ_W-1:0]    n,
  output logic                              done,
  output logic [wrtd_pkg::ROOT_W-1:0]       root
);
  import wrtd_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ROOT_W - 1);
  localparam logic [SQ_W-1:0] TOP_BIT = SQ_W'(1) << (2 * (ROOT_W - 1));

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SQ_W-1:0]   rem;
  logic [SQ_W-1:0]   res;
  logic [SQ_W-1:0]   bitv;
  logic [SQ_W:0]     trial;
  logic              fits;

  // one result bit per cycle
  assign trial = {1'b0, res} + {1'b0, bitv};
  assign fits  = ({1'b0, rem} >= trial);
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (cnt == LAST_CNT);
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= n;
      res  <= '0;
      bitv <= TOP_BIT;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - trial[SQ_W-1:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (cnt == LAST_CNT) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/waypoint_rotate_then_drive_control_core.sv @@
// the CORDIC iterations, then the 17-step bit-serial square root when the heading
//   error is within the deadzone, set the latency
// one pose at a time: the next pose can be taken in the cycle after the command is registered
// synchronous active-high reset: gains and deadzones to defaults, waypoint index to 0
`default_nettype none

module waypoint_rotate_then_drive_control_core #(
  parameter int CORDIC_STEPS = wrtd_pkg::CORDIC_STEPS_DEF,
  parameter int INDEX_WIDTH  = wrtd_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  wrtd_pose_if.sink  pose,
  wrtd_cmd_if.source cmd,
  wrtd_cfg_if.sink   cfg
);
  import wrtd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORDIC,
    S_CHECK,
    S_ROT_MUL,
    S_ROT_RND,
    S_SQ_DX,
    S_SQ_DY,
    S_SQ_SUM,
    S_SQRT,
    S_DRV_MUL,
    S_DRV_RND,
    S_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [GAIN_W-1:0] position_gain;
  logic [GAIN_W-1:0] rotation_gain;
  logic [GAIN_W-1:0] distance_deadzone;
  logic [HDZ_W-1:0]  heading_deadzone;

  logic [INDEX_WIDTH-1:0] waypoint_index;
  logic [INDEX_WIDTH-1:0] prev_index;
  logic [31:0]            index_wide;

  // per-item working registers
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic signed [COORD_W-1:0] heading;
  logic signed [ERR_W-1:0]   err;
  logic [ERR_W-1:0]          abs_err;
  logic [SQ_W-1:0]           sq;
  logic [ROOT_W-1:0]         distance;
  logic signed [CMD_W-1:0]   c1;
  logic signed [CMD_W-1:0]   c2;
  logic                      reached;
  logic                      cordic_start;
  logic                      sqrt_start;

  // output register
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_right;
  logic signed [OUT_W-1:0] out_left;
  logic                    out_reached;
  logic [REQ_W-1:0]        out_req;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd16;
  logic signed [PROD_W-1:0] rnd12;

  logic                      cordic_done;
  logic signed [ANGLE_W-1:0] cordic_angle;
  logic                      sqrt_done;
  logic [ROOT_W-1:0]         sqrt_root;

  logic signed [COORD_W-1:0] tx_sel;
  logic signed [COORD_W-1:0] ty_sel;
  logic signed [CMD_W:0]     right_sum;
  logic signed [CMD_W:0]     left_sum;
  logic                      in_fire;
  logic                      out_free;
  logic                      near;

  wrtd_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .dx    (dx),
    .dy    (dy),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  wrtd_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .n     (sq),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // handshakes
  assign pose.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign in_fire    = pose.valid && pose.ready;
  assign out_free   = !out_valid || cmd.ready;

  assign cmd.valid           = out_valid;
  assign cmd.right_speed     = out_right;
  assign cmd.left_speed      = out_left;
  assign cmd.point_reached   = out_reached;
  assign cmd.requested_index = out_req;

  // target is the origin while the index is zero
  assign tx_sel = (waypoint_index != '0) ? pose.target_x : '0;
  assign ty_sel = (waypoint_index != '0) ? pose.target_y : '0;

  // index before the increment, wrapped at the index width
  assign prev_index = waypoint_index - 1'b1;
  assign index_wide = 32'(prev_index);
  assign abs_err    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign near       = (sqrt_root <= {1'b0, distance_deadzone});

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_ROT_MUL: begin
        mul_a = MUL_W'(err);
        mul_b = MUL_W'({1'b0, rotation_gain});
      end
      S_SQ_DX: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
      end
      S_SQ_DY: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      S_DRV_MUL: begin
        mul_a = MUL_W'({1'b0, distance});
        mul_b = MUL_W'({1'b0, position_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // round half up after the gain products
  assign rnd16 = prod + PROD_W'(32768);
  assign rnd12 = prod + PROD_W'(2048);

  // wheel commands
  assign right_sum = {c1[CMD_W-1], c1} - {c2[CMD_W-1], c2};
  assign left_sum  = {c1[CMD_W-1], c1} + {c2[CMD_W-1], c2};

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    cordic_start <= !rst && in_fire;
    sqrt_start   <= !rst && (state == S_SQ_SUM);
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      waypoint_index    <= '0;
      position_gain     <= POSITION_GAIN_RST;
      rotation_gain     <= ROTATION_GAIN_RST;
      distance_deadzone <= DISTANCE_DEADZONE_RST;
      heading_deadzone  <= HEADING_DEADZONE_RST;
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_POSITION_GAIN:     position_gain     <= cfg.data;
          REG_ROTATION_GAIN:     rotation_gain     <= cfg.data;
          REG_DISTANCE_DEADZONE: distance_deadzone <= cfg.data;
          REG_HEADING_DEADZONE:  heading_deadzone  <= cfg.data[HDZ_W-1:0];
          default: ;
        endcase
      end

      // command taken while no new one is being loaded
      if (out_valid && cmd.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            dx           <= {tx_sel[COORD_W-1], tx_sel} - {pose.robot_x[COORD_W-1], pose.robot_x};
            dy           <= {ty_sel[COORD_W-1], ty_sel} - {pose.robot_y[COORD_W-1], pose.robot_y};
            heading      <= pose.robot_heading;
            c1           <= '0;
            c2           <= '0;
            reached      <= 1'b0;
            state        <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cordic_done) begin
            err   <= {cordic_angle[ANGLE_W-1], cordic_angle}
                   - {{(ERR_W-COORD_W){heading[COORD_W-1]}}, heading};
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (abs_err > {{(ERR_W-HDZ_W){1'b0}}, heading_deadzone}) begin
            state <= S_ROT_MUL;
          end else begin
            state <= S_SQ_DX;
          end
        end
        S_ROT_MUL: begin
          state <= S_ROT_RND;
        end
        S_ROT_RND: begin
          c2    <= CMD_W'(rnd16 >>> 16);
          state <= S_FINISH;
        end
        S_SQ_DX: begin
          state <= S_SQ_DY;
        end
        S_SQ_DY: begin
          sq    <= prod[SQ_W-1:0];
          state <= S_SQ_SUM;
        end
        S_SQ_SUM: begin
          sq         <= sq + prod[SQ_W-1:0];
          state      <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_done) begin
            distance <= sqrt_root;
            if (near) begin
              reached        <= 1'b1;
              waypoint_index <= waypoint_index + 1'b1;
              state          <= S_FINISH;
            end else begin
              state <= S_DRV_MUL;
            end
          end
        end
        S_DRV_MUL: begin
          state <= S_DRV_RND;
        end
        S_DRV_RND: begin
          c1    <= CMD_W'(rnd12 >>> 12);
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_right   <= sat_out(right_sum);
            out_left    <= sat_out(left_sum);
            out_reached <= reached;
            out_req     <= reached ? index_wide[REQ_W-1:0] : '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the angle unit only finishes while the sequencer waits for it
  a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> state == S_CORDIC)
    else $error("cordic done outside its wait state");

  // the root unit only finishes while the sequencer waits for it
  a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == S_SQRT)
    else $error("square root done outside its wait state");

  // an arrival advances the waypoint index by exactly one
  a_index_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT && sqrt_done && near)
      |=> waypoint_index == INDEX_WIDTH'($past(waypoint_index) + 1'b1))
    else $error("waypoint index did not advance on arrival");

  // a reached point always commands a stop
  a_reached_stops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reached) |-> (out_right == '0 && out_left == '0))
    else $error("reached point with nonzero wheel command");

endmodule

`default_nettype wire
